>>> hdl/cdg_pkg.sv
`default_nettype none
package cdg_pkg;

    localparam int SCREEN_WIDTH  = 300;
    localparam int SCREEN_HEIGHT = 216;
    localparam int BAND_ROWS     = 12;
    localparam int SCREEN_DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int BAND_DEPTH    = SCREEN_WIDTH * BAND_ROWS;
    localparam int MOVE_DEPTH    = SCREEN_DEPTH - BAND_DEPTH;
    localparam int MEM_AW        = 16;
    localparam int SCR_AW        = $clog2(SCREEN_DEPTH);
    localparam int BUF_AW        = $clog2(BAND_DEPTH);

    localparam int REGION_WIDTH  = 48;
    localparam int REGION_HEIGHT = 48;
    localparam int IMG_W         = SCREEN_WIDTH - 12;
    localparam int IMG_H         = SCREEN_HEIGHT - 12;
    localparam int REG_COLS      = (IMG_W + REGION_WIDTH - 1) / REGION_WIDTH;
    localparam int REG_ROWS      = (IMG_H + REGION_HEIGHT - 1) / REGION_HEIGHT;
    localparam int NUM_REGIONS   = 24;

    localparam logic [5:0] GFX_MODE  = 6'd9;
    localparam logic [1:0] VSCR_DOWN = 2'd1;
    localparam logic [1:0] VSCR_UP   = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPLY  = 2'd0,
        CMD_PIXEL  = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_REWIND = 2'd3
    } cdg_cmd_t;

    typedef enum logic [5:0] {
        OP_MEM_PRESET    = 6'd1,
        OP_BORDER_PRESET = 6'd2,
        OP_TILE          = 6'd6,
        OP_SCROLL_PRESET = 6'd20,
        OP_SCROLL_COPY   = 6'd24,
        OP_TRANSPARENT   = 6'd28,
        OP_PAL_LOW       = 6'd30,
        OP_PAL_HIGH      = 6'd31,
        OP_TILE_XOR      = 6'd38
    } cdg_op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TILE,
        ST_SAVE,
        ST_MOVE,
        ST_RESTORE,
        ST_PIXEL,
        ST_FIN
    } cdg_state_t;

    typedef enum logic [1:0] {
        WK_CONST,
        WK_SCR,
        WK_BUF,
        WK_XOR
    } cdg_wkind_t;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [3:0]        wdata;
        logic              re;
        logic [MEM_AW-1:0] raddr;
    } cdg_mem_req_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  packet_command;
        logic [7:0]  packet_instruction;
        logic [63:0] packet_data_low;
        logic [63:0] packet_data_high;
        logic [8:0]  pixel_column;
        logic [7:0]  pixel_row;
    } cdg_req_t;

    typedef struct packed {
        logic [3:0]  pixel_index;
        logic [3:0]  pixel_red;
        logic [3:0]  pixel_green;
        logic [3:0]  pixel_blue;
        logic [23:0] updated_mask;
        logic        has_tiles;
        logic [3:0]  border_index;
        logic        border_known;
        logic [3:0]  transparent_index;
        logic        transparent_known;
        logic        is_tile_packet;
    } cdg_rsp_t;

endpackage
`default_nettype wire

>>> hdl/cdg_ram.sv
`default_nettype none
module cdg_ram
    import cdg_pkg::*;
#(
    parameter int DEPTH  = SCREEN_DEPTH,
    parameter int ADDR_W = SCR_AW
)
(
    input  wire logic         clk,
    input  wire cdg_mem_req_t mem_port,
    output logic [3:0]        rdata
);

    logic [3:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_port.we)
        begin
            mem[mem_port.waddr[ADDR_W-1:0]] <= mem_port.wdata;
        end
        if (mem_port.re)
        begin
            rdata <= mem[mem_port.raddr[ADDR_W-1:0]];
        end
    end

endmodule
`default_nettype wire

>>> hdl/cdg_ctrl.sv
`default_nettype none
module cdg_ctrl
    import cdg_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire cdg_req_t     req,
    output logic              done,
    output cdg_rsp_t          rsp,
    output cdg_mem_req_t      scr_port,
    input  wire logic [3:0]   scr_rdata,
    output cdg_mem_req_t      buf_port,
    input  wire logic [3:0]   buf_rdata
);

    function automatic logic [NUM_REGIONS-1:0] tile_regions(input logic [8:0] trow,
                                                             input logic [8:0] tcol);
        logic [NUM_REGIONS-1:0] m;
        m = '0;
        for (int i = 0; i < NUM_REGIONS; i++)
        begin
            if (i < REG_COLS * REG_ROWS)
            begin
                if (int'(tcol) >= (i % REG_COLS) * REGION_WIDTH &&
                    int'(tcol) <= (i % REG_COLS) * REGION_WIDTH + REGION_WIDTH + 6 &&
                    int'(trow) >= (i / REG_COLS) * REGION_HEIGHT &&
                    int'(trow) <= (i / REG_COLS) * REGION_HEIGHT + REGION_HEIGHT + 12)
                begin
                    m[i] = 1'b1;
                end
            end
        end
        return m;
    endfunction

    cdg_state_t state_reg, state_next;

    logic [MEM_AW-1:0]  cnt_reg;
    logic [2:0]         tx_reg;
    logic [3:0]         ty_reg;
    logic [MEM_AW-1:0]  rowbase_reg;
    logic [8:0]         tcol_reg;
    logic [95:0]        tbits_reg;
    logic [3:0]         c0_reg, c1_reg, fill_reg;
    logic               xor_reg, up_reg, rotate_reg, notify_reg;
    logic               pix_ok_reg, is_tile_reg;
    logic [3:0]         pix_reg;
    logic               preset_v_reg, border_v_reg, transp_v_reg;
    logic [3:0]         preset_c_reg, border_c_reg, transp_c_reg;
    logic [23:0]        dirty_reg;
    logic               tiles_reg;
    logic [11:0]        pal_reg [16];
    logic               wv_reg, wbuf_reg;
    cdg_wkind_t         wkind_reg;
    logic [MEM_AW-1:0]  waddr_reg;
    logic [3:0]         wcol_reg;
    logic               done_reg;
    cdg_rsp_t           rsp_reg;

    // Packet decode.
    logic [127:0] data;
    logic         accept, gfx, tile_ok, scroll_ok, is_tile;
    cdg_op_t      op;
    logic [3:0]   d0;
    logic [7:0]   d2, d3;
    logic [8:0]   trow, tcol;

    assign busy   = (state_reg != ST_IDLE) || wv_reg;
    assign accept = start && !busy;
    assign data   = {req.packet_data_high, req.packet_data_low};
    assign gfx    = (req.packet_command[5:0] == GFX_MODE);
    assign op     = cdg_op_t'(req.packet_instruction[5:0]);
    assign d0     = data[3:0];
    assign d2     = data[23:16];
    assign d3     = data[31:24];
    assign trow   = 9'(d2[4:0]) * 9'd12;
    assign tcol   = 9'(d3[5:0]) * 9'd6;
    assign tile_ok   = (trow < 9'(SCREEN_HEIGHT)) && (tcol < 9'(SCREEN_WIDTH));
    assign scroll_ok = (d2[3:0] == 4'd0) && (d2[5:4] == VSCR_DOWN || d2[5:4] == VSCR_UP);
    assign is_tile   = gfx && (op == OP_TILE || op == OP_TILE_XOR);

    // Sweep issue stage.
    logic              iss, last, iss_buf;
    cdg_wkind_t        iss_kind;
    logic [MEM_AW-1:0] iss_waddr, scr_raddr;
    logic [BUF_AW-1:0] buf_raddr;
    logic              scr_re, buf_re;
    logic [3:0]        iss_col;
    logic [7:0]        tbyte;

    assign tbyte = tbits_reg[{ty_reg, 3'b000} +: 8];

    always_comb
    begin
        iss       = 1'b0;
        last      = 1'b0;
        iss_buf   = 1'b0;
        iss_kind  = WK_CONST;
        iss_waddr = cnt_reg;
        iss_col   = fill_reg;
        scr_re    = 1'b0;
        scr_raddr = cnt_reg;
        buf_re    = 1'b0;
        buf_raddr = cnt_reg[BUF_AW-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                scr_re    = accept;
                scr_raddr = MEM_AW'(req.pixel_row) * MEM_AW'(SCREEN_WIDTH)
                          + MEM_AW'(req.pixel_column);
            end
            ST_CLEAR:
            begin
                iss  = 1'b1;
                last = (cnt_reg == MEM_AW'(SCREEN_DEPTH - 1));
            end
            ST_SAVE:
            begin
                iss       = 1'b1;
                iss_buf   = 1'b1;
                iss_kind  = WK_SCR;
                scr_re    = 1'b1;
                scr_raddr = up_reg ? cnt_reg : cnt_reg + MEM_AW'(MOVE_DEPTH);
                last      = (cnt_reg == MEM_AW'(BAND_DEPTH - 1));
            end
            ST_MOVE:
            begin
                iss      = 1'b1;
                iss_kind = WK_SCR;
                scr_re   = 1'b1;
                if (up_reg)
                begin
                    scr_raddr = cnt_reg + MEM_AW'(BAND_DEPTH);
                    iss_waddr = cnt_reg;
                end
                else
                begin
                    scr_raddr = MEM_AW'(MOVE_DEPTH - 1) - cnt_reg;
                    iss_waddr = MEM_AW'(SCREEN_DEPTH - 1) - cnt_reg;
                end
                last = (cnt_reg == MEM_AW'(MOVE_DEPTH - 1));
            end
            ST_RESTORE:
            begin
                iss       = 1'b1;
                iss_kind  = rotate_reg ? WK_BUF : WK_CONST;
                buf_re    = rotate_reg;
                iss_waddr = up_reg ? cnt_reg + MEM_AW'(MOVE_DEPTH) : cnt_reg;
                last      = (cnt_reg == MEM_AW'(BAND_DEPTH - 1));
            end
            ST_TILE:
            begin
                iss       = 1'b1;
                iss_kind  = xor_reg ? WK_XOR : WK_CONST;
                iss_waddr = rowbase_reg + MEM_AW'(tcol_reg) + MEM_AW'(tx_reg);
                scr_re    = xor_reg;
                scr_raddr = iss_waddr;
                iss_col   = tbyte[3'd5 - tx_reg] ? c1_reg : c0_reg;
                last      = (ty_reg == 4'd11) && (tx_reg == 3'd5);
            end
            ST_PIXEL, ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (cdg_cmd_t'(req.command))
                        CMD_APPLY:
                        begin
                            state_next = ST_FIN;
                            if (gfx)
                            begin
                                case (op)
                                    OP_MEM_PRESET, OP_BORDER_PRESET: state_next = ST_CLEAR;
                                    OP_TILE, OP_TILE_XOR:
                                        state_next = tile_ok ? ST_TILE : ST_FIN;
                                    OP_SCROLL_PRESET, OP_SCROLL_COPY:
                                        state_next = scroll_ok ? ST_SAVE : ST_FIN;
                                    default: state_next = ST_FIN;
                                endcase
                            end
                        end
                        CMD_PIXEL:  state_next = ST_PIXEL;
                        CMD_CLEAR:  state_next = ST_FIN;
                        CMD_REWIND: state_next = ST_CLEAR;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_CLEAR:   if (last) state_next = notify_reg ? ST_FIN : ST_IDLE;
            ST_SAVE:    if (last) state_next = ST_MOVE;
            ST_MOVE:    if (last) state_next = ST_RESTORE;
            ST_RESTORE: if (last) state_next = ST_FIN;
            ST_TILE:    if (last) state_next = ST_FIN;
            ST_PIXEL:   state_next = ST_FIN;
            ST_FIN:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Memory ports.
    logic [3:0] wdata;

    always_comb
    begin
        unique case (wkind_reg)
            WK_CONST: wdata = wcol_reg;
            WK_SCR:   wdata = scr_rdata;
            WK_BUF:   wdata = buf_rdata;
            WK_XOR:   wdata = scr_rdata ^ wcol_reg;
            default:  wdata = wcol_reg;
        endcase
    end

    always_comb
    begin
        scr_port.we    = wv_reg && !wbuf_reg;
        scr_port.waddr = waddr_reg;
        scr_port.wdata = wdata;
        scr_port.re    = scr_re;
        scr_port.raddr = scr_raddr;
        buf_port.we    = wv_reg && wbuf_reg;
        buf_port.waddr = waddr_reg;
        buf_port.wdata = wdata;
        buf_port.re    = buf_re;
        buf_port.raddr = MEM_AW'(buf_raddr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            tx_reg       <= '0;
            ty_reg       <= '0;
            fill_reg     <= '0;
            notify_reg   <= 1'b0;
            preset_v_reg <= 1'b0;
            border_v_reg <= 1'b0;
            transp_v_reg <= 1'b0;
            preset_c_reg <= '0;
            border_c_reg <= '0;
            transp_c_reg <= '0;
            dirty_reg    <= '1;
            tiles_reg    <= 1'b0;
            wv_reg       <= 1'b0;
            done_reg     <= 1'b0;
            for (int k = 0; k < 16; k++)
            begin
                pal_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wv_reg    <= iss;
            done_reg  <= (state_reg == ST_FIN);
            if (iss)
            begin
                cnt_reg <= last ? '0 : cnt_reg + 1'b1;
            end
            if (state_reg == ST_TILE)
            begin
                tx_reg <= (tx_reg == 3'd5) ? 3'd0 : tx_reg + 3'd1;
                if (tx_reg == 3'd5)
                begin
                    ty_reg <= last ? 4'd0 : ty_reg + 4'd1;
                end
            end
            if (accept)
            begin
                unique case (cdg_cmd_t'(req.command))
                    CMD_APPLY:
                    begin
                        if (gfx)
                        begin
                            case (op)
                                OP_MEM_PRESET:
                                begin
                                    preset_v_reg <= 1'b1;
                                    preset_c_reg <= d0;
                                    fill_reg     <= d0;
                                    notify_reg   <= 1'b1;
                                    dirty_reg    <= '1;
                                    if (!border_v_reg)
                                    begin
                                        border_v_reg <= 1'b1;
                                        border_c_reg <= d0;
                                    end
                                end
                                OP_BORDER_PRESET:
                                begin
                                    border_v_reg <= 1'b1;
                                    border_c_reg <= d0;
                                    notify_reg   <= 1'b1;
                                    dirty_reg    <= '1;
                                    if (!preset_v_reg)
                                    begin
                                        preset_v_reg <= 1'b1;
                                        preset_c_reg <= d0;
                                        fill_reg     <= d0;
                                    end
                                    else
                                    begin
                                        fill_reg <= preset_c_reg;
                                    end
                                end
                                OP_TILE, OP_TILE_XOR:
                                begin
                                    if (tile_ok)
                                    begin
                                        dirty_reg <= dirty_reg | tile_regions(trow, tcol);
                                        tiles_reg <= 1'b1;
                                    end
                                end
                                OP_SCROLL_PRESET, OP_SCROLL_COPY:
                                begin
                                    fill_reg <= d0;
                                    if (scroll_ok)
                                    begin
                                        dirty_reg <= '1;
                                    end
                                end
                                OP_TRANSPARENT:
                                begin
                                    transp_v_reg <= 1'b1;
                                    transp_c_reg <= d0;
                                    dirty_reg    <= '1;
                                end
                                OP_PAL_LOW, OP_PAL_HIGH:
                                begin
                                    for (int k = 0; k < 8; k++)
                                    begin
                                        pal_reg[{op == OP_PAL_HIGH, 3'(k)}] <=
                                            {data[16*k +: 6], data[16*k+8 +: 6]};
                                    end
                                    dirty_reg <= '1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                    CMD_PIXEL:
                    begin
                    end
                    CMD_CLEAR:
                    begin
                        dirty_reg <= '0;
                    end
                    CMD_REWIND:
                    begin
                        fill_reg     <= '0;
                        notify_reg   <= 1'b1;
                        preset_v_reg <= 1'b0;
                        border_v_reg <= 1'b0;
                        transp_v_reg <= 1'b0;
                        preset_c_reg <= '0;
                        border_c_reg <= '0;
                        transp_c_reg <= '0;
                        dirty_reg    <= '1;
                        tiles_reg    <= 1'b0;
                        for (int k = 0; k < 16; k++)
                        begin
                            pal_reg[k] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Item payload and write stage; no reset needed.
    always_ff @(posedge clk)
    begin
        wbuf_reg  <= iss_buf;
        wkind_reg <= iss_kind;
        waddr_reg <= iss_waddr;
        wcol_reg  <= iss_col;
        if (state_reg == ST_TILE && tx_reg == 3'd5)
        begin
            rowbase_reg <= rowbase_reg + MEM_AW'(SCREEN_WIDTH);
        end
        if (accept)
        begin
            rowbase_reg <= MEM_AW'(trow) * MEM_AW'(SCREEN_WIDTH);
            tcol_reg    <= tcol;
            tbits_reg   <= data[127:32];
            c0_reg      <= data[3:0];
            c1_reg      <= data[11:8];
            xor_reg     <= (op == OP_TILE_XOR);
            up_reg      <= (d2[5:4] == VSCR_UP);
            rotate_reg  <= (op == OP_SCROLL_COPY);
            is_tile_reg <= is_tile;
            pix_ok_reg  <= (cdg_cmd_t'(req.command) == CMD_PIXEL) &&
                           (req.pixel_column < 9'(SCREEN_WIDTH)) &&
                           (req.pixel_row < 8'(SCREEN_HEIGHT));
            pix_reg     <= '0;
        end
        if (state_reg == ST_PIXEL)
        begin
            pix_reg <= pix_ok_reg ? scr_rdata : 4'd0;
        end
        if (state_reg == ST_FIN)
        begin
            rsp_reg.pixel_index       <= pix_reg;
            rsp_reg.pixel_red         <= pix_ok_reg ? pal_reg[pix_reg][11:8] : 4'd0;
            rsp_reg.pixel_green       <= pix_ok_reg ? pal_reg[pix_reg][7:4] : 4'd0;
            rsp_reg.pixel_blue        <= pix_ok_reg ? pal_reg[pix_reg][3:0] : 4'd0;
            rsp_reg.updated_mask      <= dirty_reg;
            rsp_reg.has_tiles         <= tiles_reg;
            rsp_reg.border_index      <= border_v_reg ? border_c_reg : 4'd0;
            rsp_reg.border_known      <= border_v_reg;
            rsp_reg.transparent_index <= transp_v_reg ? transp_c_reg : 4'd0;
            rsp_reg.transparent_known <= transp_v_reg;
            rsp_reg.is_tile_packet    <= is_tile_reg;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == ST_IDLE)
        else $error("result strobe outside idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("accepted item did not start work");

    a_write_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        iss |=> wv_reg)
        else $error("issued write lost");

    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg) == ST_IDLE) |-> !wv_reg)
        else $error("memory write while idle");
`endif

endmodule
`default_nettype wire

>>> hdl/cdg_subcode_graphics_decoder_top.sv
`default_nettype none
// Channel   Signals                Direction  Meaning
// request   start, busy, req       in         one command item, taken when start && !busy
// result    done, rsp              out        one result item per command, one-cycle strobe
//
// A memory or border preset sweeps the whole screen memory at one entry a cycle.
// A vertical scroll copies a 12-row band out, moves the rest and refills the band,
// all through the single write stage that the screen memory and band buffer share.
// After reset, and after a rewind, a clearing pass runs with busy high;
// after reset busy stays high until the last write lands.
// The receiver cannot stall: each result is presented for exactly one cycle.
module cdg_subcode_graphics_decoder_top
    import cdg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire cdg_req_t req,
    output logic          done,
    output cdg_rsp_t      rsp
);

    cdg_mem_req_t scr_port;
    cdg_mem_req_t buf_port;
    logic [3:0]   scr_rdata;
    logic [3:0]   buf_rdata;

    // The control unit sequences every command and owns the small state.
    cdg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .scr_port  (scr_port),
        .scr_rdata (scr_rdata),
        .buf_port  (buf_port),
        .buf_rdata (buf_rdata)
    );

    // Screen of colour indices, one entry per pixel.
    cdg_ram #(
        .DEPTH  (SCREEN_DEPTH),
        .ADDR_W (SCR_AW)
    ) u_screen (
        .clk      (clk),
        .mem_port (scr_port),
        .rdata    (scr_rdata)
    );

    // Band buffer holding the rows pushed out by a scroll.
    cdg_ram #(
        .DEPTH  (BAND_DEPTH),
        .ADDR_W (BUF_AW)
    ) u_band (
        .clk      (clk),
        .mem_port (buf_port),
        .rdata    (buf_rdata)
    );

endmodule
`default_nettype wire

>>> dv/cdg_subcode_graphics_decoder_top_tb.sv
`timescale 1ns / 1ps

module cdg_subcode_graphics_decoder_top_tb;
    import cdg_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    cdg_req_t req;
    logic     done;
    cdg_rsp_t rsp;

    cdg_subcode_graphics_decoder_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predicted decoder state. It mirrors the screen, the palette and the
    // colour registers so that every item's status can be worked out here.
    logic [3:0]  screen_img [0:SCREEN_DEPTH-1];
    logic [11:0] palette_img [0:15];
    logic [3:0]  band_hold [0:BAND_DEPTH-1];
    logic        preset_set, border_set, transp_set;
    logic [3:0]  preset_val, border_val, transp_val;
    logic [23:0] dirty_img;
    logic        tiles_img;

    // Statuses still to come from the block, oldest first.
    cdg_rsp_t    awaited_status [$];
    cdg_rsp_t    oldest;
    int          error_count = 0;
    int          items_sent = 0;
    int          statuses_seen = 0;
    int          tiles_sent = 0;
    int          fills_sent = 0;
    bit          idling_on = 1'b1;

    function automatic void rewind_image();
        foreach (screen_img[i])
            screen_img[i] = 4'd0;
        foreach (palette_img[i])
            palette_img[i] = 12'd0;
        preset_set = 1'b0;
        border_set = 1'b0;
        transp_set = 1'b0;
        preset_val = 4'd0;
        border_val = 4'd0;
        transp_val = 4'd0;
        dirty_img  = 24'hFFFFFF;
        tiles_img  = 1'b0;
    endfunction

    function automatic logic [7:0] data_byte(cdg_req_t it, int n);
        logic [127:0] whole;
        whole = {it.packet_data_high, it.packet_data_low};
        return whole[8*n +: 8];
    endfunction

    function automatic void paint_tile(cdg_req_t it, bit use_xor);
        logic [3:0] c0, c1, c;
        logic [7:0] bits;
        int ty, tx, idx;
        c0 = 4'(data_byte(it, 0) & 8'h0F);
        c1 = 4'(data_byte(it, 1) & 8'h0F);
        ty = int'(data_byte(it, 2) & 8'h1F) * 12;
        tx = int'(data_byte(it, 3) & 8'h3F) * 6;
        idx = 0;
        if (ty >= SCREEN_HEIGHT || tx >= SCREEN_WIDTH)
            return;
        for (int y = 0; y < 12; y++)
        begin
            bits = data_byte(it, 4 + y);
            for (int x = 0; x < 6; x++)
            begin
                c = bits[5 - x] ? c1 : c0;
                if (use_xor)
                    screen_img[(ty + y) * SCREEN_WIDTH + tx + x] ^= c;
                else
                    screen_img[(ty + y) * SCREEN_WIDTH + tx + x] = c;
            end
        end
        ty -= 12;
        tx -= 6;
        for (int y = 0; y < IMG_H; y += REGION_HEIGHT)
            for (int x = 0; x < IMG_W; x += REGION_WIDTH)
            begin
                if (tx + 6 >= x && tx <= x + REGION_WIDTH &&
                    ty + 12 >= y && ty <= y + REGION_HEIGHT && idx < 24)
                    dirty_img[idx] = 1'b1;
                idx++;
            end
        tiles_img = 1'b1;
    endfunction

    function automatic void shift_screen(cdg_req_t it, bit rotate);
        logic [3:0] fill;
        logic [7:0] v;
        fill = 4'(data_byte(it, 0) & 8'h0F);
        v = data_byte(it, 2);
        if (v[3:0] != 4'd0)
            return;
        if (v[5:4] == VSCR_DOWN)
        begin
            for (int i = 0; i < BAND_DEPTH; i++)
                band_hold[i] = screen_img[MOVE_DEPTH + i];
            for (int i = MOVE_DEPTH - 1; i >= 0; i--)
                screen_img[i + BAND_DEPTH] = screen_img[i];
            for (int i = 0; i < BAND_DEPTH; i++)
                screen_img[i] = rotate ? band_hold[i] : fill;
            dirty_img = 24'hFFFFFF;
        end
        else if (v[5:4] == VSCR_UP)
        begin
            for (int i = 0; i < BAND_DEPTH; i++)
                band_hold[i] = screen_img[i];
            for (int i = 0; i < MOVE_DEPTH; i++)
                screen_img[i] = screen_img[i + BAND_DEPTH];
            for (int i = 0; i < BAND_DEPTH; i++)
                screen_img[MOVE_DEPTH + i] = rotate ? band_hold[i] : fill;
            dirty_img = 24'hFFFFFF;
        end
    endfunction

    function automatic void load_half(cdg_req_t it, int base);
        logic [7:0] h, l;
        for (int k = 0; k < 8; k++)
        begin
            h = data_byte(it, 2 * k);
            l = data_byte(it, 2 * k + 1);
            palette_img[base + k] = {h[5:2], h[1:0], l[5:4], l[3:0]};
        end
        dirty_img = 24'hFFFFFF;
    endfunction

    // Applies one command item to the predicted state and returns the status
    // the block should report for it.
    function automatic cdg_rsp_t decode_item(cdg_req_t it);
        cdg_rsp_t   s;
        logic       gfx;
        logic [5:0] op;
        logic [3:0] d0;
        logic [11:0] rgb;
        s   = '0;
        gfx = it.packet_command[5:0] == GFX_MODE;
        op  = it.packet_instruction[5:0];
        d0  = it.packet_data_low[3:0];
        case (cdg_cmd_t'(it.command))
            CMD_APPLY:
                if (gfx)
                    case (op)
                        OP_MEM_PRESET, OP_BORDER_PRESET:
                        begin
                            if (op == OP_MEM_PRESET)
                            begin
                                preset_val = d0;
                                preset_set = 1'b1;
                                if (!border_set)
                                begin
                                    border_val = d0;
                                    border_set = 1'b1;
                                end
                            end
                            else
                            begin
                                border_val = d0;
                                border_set = 1'b1;
                                if (!preset_set)
                                begin
                                    preset_val = d0;
                                    preset_set = 1'b1;
                                end
                            end
                            foreach (screen_img[i])
                                screen_img[i] = preset_val;
                            dirty_img = 24'hFFFFFF;
                        end
                        OP_TILE:          paint_tile(it, 1'b0);
                        OP_TILE_XOR:      paint_tile(it, 1'b1);
                        OP_SCROLL_PRESET: shift_screen(it, 1'b0);
                        OP_SCROLL_COPY:   shift_screen(it, 1'b1);
                        OP_TRANSPARENT:
                        begin
                            transp_val = d0;
                            transp_set = 1'b1;
                            dirty_img  = 24'hFFFFFF;
                        end
                        OP_PAL_LOW:       load_half(it, 0);
                        OP_PAL_HIGH:      load_half(it, 8);
                        default:          ;
                    endcase
            CMD_PIXEL:
                if (it.pixel_column < SCREEN_WIDTH && it.pixel_row < SCREEN_HEIGHT)
                begin
                    s.pixel_index = screen_img[it.pixel_row * SCREEN_WIDTH + it.pixel_column];
                    rgb           = palette_img[s.pixel_index];
                    s.pixel_red   = rgb[11:8];
                    s.pixel_green = rgb[7:4];
                    s.pixel_blue  = rgb[3:0];
                end
            CMD_CLEAR:
                dirty_img = 24'd0;
            default:
                rewind_image();
        endcase
        s.updated_mask      = dirty_img;
        s.has_tiles         = tiles_img;
        s.border_index      = border_set ? border_val : 4'd0;
        s.border_known      = border_set;
        s.transparent_index = transp_set ? transp_val : 4'd0;
        s.transparent_known = transp_set;
        s.is_tile_packet    = gfx && (op == OP_TILE || op == OP_TILE_XOR);
        return s;
    endfunction

    // Sends one item. The start line stays high straight into the next item
    // when no gap follows, so it is never lowered and raised in one step.
    task automatic send_item(cdg_req_t it);
        if (idling_on && $urandom_range(0, 2) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= it;
        do
            @(posedge clk);
        while (busy);
        awaited_status.push_back(decode_item(it));
        items_sent++;
        if (it.command == CMD_APPLY && it.packet_command[5:0] == GFX_MODE)
        begin
            if (it.packet_instruction[5:0] == OP_TILE ||
                it.packet_instruction[5:0] == OP_TILE_XOR)
                tiles_sent++;
            else if (it.packet_instruction[5:0] inside {OP_MEM_PRESET, OP_BORDER_PRESET,
                                                        OP_SCROLL_PRESET, OP_SCROLL_COPY})
                fills_sent++;
        end
    endtask

    // Holds the sender back until every status still owed has come.
    task automatic drain();
        start <= 1'b0;
        while (awaited_status.size() != 0)
            @(posedge clk);
    endtask

    function automatic cdg_req_t make_item(cdg_cmd_t cmd, logic [5:0] op,
                                           logic [127:0] data);
        cdg_req_t it;
        it.command            = cmd;
        it.packet_command     = {2'($urandom), GFX_MODE};
        it.packet_instruction = {2'($urandom), op};
        it.packet_data_low    = data[63:0];
        it.packet_data_high   = data[127:64];
        it.pixel_column       = 9'($urandom);
        it.pixel_row          = 8'($urandom);
        return it;
    endfunction

    function automatic logic [127:0] random_data();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    function automatic cdg_req_t pixel_item(int col, int row);
        cdg_req_t it;
        it = make_item(CMD_PIXEL, 6'($urandom), random_data());
        it.pixel_column = 9'(col);
        it.pixel_row    = 8'(row);
        return it;
    endfunction

    // A tile packet with its position bytes forced; the unused upper bits
    // of those bytes stay random since the block must ignore them.
    function automatic cdg_req_t tile_item(bit use_xor, int trow, int tcol,
                                           logic [127:0] data);
        data[23:16] = {3'($urandom), 5'(trow)};
        data[31:24] = {2'($urandom), 6'(tcol)};
        return make_item(CMD_APPLY, use_xor ? OP_TILE_XOR : OP_TILE, data);
    endfunction

    function automatic cdg_req_t scroll_item(bit rotate, logic [1:0] vcmd,
                                             logic [3:0] offset);
        logic [127:0] data;
        data = random_data();
        data[23:16] = {2'($urandom), vcmd, offset};
        return make_item(CMD_APPLY, rotate ? OP_SCROLL_COPY : OP_SCROLL_PRESET, data);
    endfunction

    // Reads at power-up: corners, the far edge, and addresses off the screen.
    task automatic test_reset_reads();
        send_item(pixel_item(0, 0));
        send_item(pixel_item(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1));
        send_item(pixel_item(SCREEN_WIDTH, 0));
        send_item(pixel_item(0, SCREEN_HEIGHT));
        send_item(pixel_item(511, 255));
    endtask

    // Packets that are not graphics or carry an unknown opcode change nothing;
    // a clear empties the mask.
    task automatic test_packet_filter();
        cdg_req_t it;
        it = make_item(CMD_APPLY, OP_MEM_PRESET, random_data());
        it.packet_command = 8'hFF;
        send_item(it);
        send_item(make_item(CMD_APPLY, 6'd63, {128{1'b1}}));
        send_item(make_item(CMD_CLEAR, OP_TILE, random_data()));
    endtask

    // Border first then memory preset, a rewind, then memory preset alone,
    // so each one stands in for the other while it is still unset.
    task automatic test_presets();
        send_item(make_item(CMD_APPLY, OP_BORDER_PRESET, 128'h5));
        send_item(make_item(CMD_APPLY, OP_MEM_PRESET, {{120{1'b1}}, 8'hF9}));
        send_item(pixel_item(150, 100));
        send_item(make_item(CMD_REWIND, OP_TILE, random_data()));
        send_item(make_item(CMD_APPLY, OP_MEM_PRESET, 128'h3));
    endtask

    // Tiles at both extremes of the grid, out of range, and an XOR tile.
    task automatic test_tiles();
        send_item(tile_item(1'b0, 0, 0, random_data()));
        send_item(tile_item(1'b0, 17, 49, random_data()));
        send_item(tile_item(1'b0, 18, 50, random_data()));
        send_item(tile_item(1'b1, 17, 49, {128{1'b1}}));
        send_item(pixel_item(SCREEN_WIDTH - 1, SCREEN_HEIGHT - 1));
    endtask

    task automatic test_palette_and_transparent();
        send_item(make_item(CMD_APPLY, OP_PAL_LOW, {128{1'b1}}));
        send_item(make_item(CMD_APPLY, OP_PAL_HIGH, random_data()));
        send_item(make_item(CMD_APPLY, OP_TRANSPARENT, 128'hF));
        send_item(pixel_item(0, 0));
        send_item(pixel_item(297, 210));
    endtask

    // Real scrolls in both directions, then the forms that must do nothing.
    task automatic test_scrolls();
        send_item(scroll_item(1'b0, VSCR_DOWN, 4'd0));
        send_item(scroll_item(1'b1, VSCR_UP, 4'd0));
        send_item(scroll_item(1'b1, VSCR_DOWN, 4'd15));
        send_item(scroll_item(1'b0, 2'd3, 4'd0));
    endtask

    // Mostly well-formed tiles and reads with random content, some palette
    // and colour packets, noise, and only the odd full-screen operation.
    task automatic test_random_items(int count);
        cdg_req_t it;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n == count - 20)
                idling_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                it = tile_item($urandom_range(0, 1),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                          : $urandom_range(0, 17),
                               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                          : $urandom_range(0, 49),
                               random_data());
            else if (pick < 55)
            begin
                if ($urandom_range(0, 9) == 0)
                    it = make_item(CMD_PIXEL, 6'($urandom), random_data());
                else
                    it = pixel_item($urandom_range(0, SCREEN_WIDTH - 1),
                                    $urandom_range(0, SCREEN_HEIGHT - 1));
            end
            else if (pick < 63)
                it = make_item(CMD_APPLY, $urandom_range(0, 1) ? OP_PAL_HIGH : OP_PAL_LOW,
                               random_data());
            else if (pick < 67)
                it = make_item(CMD_APPLY, OP_TRANSPARENT, random_data());
            else if (pick < 72)
                it = make_item(CMD_CLEAR, 6'($urandom), random_data());
            else if (pick < 82)
            begin
                it = make_item(CMD_APPLY, 6'($urandom), random_data());
                it.packet_command     = 8'($urandom);
                it.packet_instruction = 8'($urandom);
                if (it.packet_command[5:0] == GFX_MODE &&
                    it.packet_instruction[5:0] inside {OP_MEM_PRESET, OP_BORDER_PRESET,
                                                       OP_SCROLL_PRESET, OP_SCROLL_COPY})
                    it.packet_command[0] = 1'b0;
            end
            else if (pick < 88)
                it = make_item(CMD_APPLY, 6'd40 + 6'($urandom_range(0, 23)), random_data());
            else if (pick < 97)
                it = ($urandom_range(0, 1) == 0)
                    ? scroll_item($urandom_range(0, 1), 2'($urandom),
                                  4'($urandom_range(1, 15)))
                    : scroll_item($urandom_range(0, 1), $urandom_range(0, 1) ? 2'd0 : 2'd3,
                                  4'd0);
            else if (pick < 99)
            begin
                case ($urandom_range(0, 3))
                    0: it = make_item(CMD_APPLY, OP_MEM_PRESET, random_data());
                    1: it = make_item(CMD_APPLY, OP_BORDER_PRESET, random_data());
                    default: it = scroll_item($urandom_range(0, 1),
                                              $urandom_range(0, 1) ? VSCR_UP : VSCR_DOWN, 4'd0);
                endcase
            end
            else
                it = make_item(CMD_REWIND, 6'($urandom), random_data());
            send_item(it);
            if (n == count / 2)
                drain();
        end
    endtask

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Each strobed status is matched against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            statuses_seen++;
            if (awaited_status.size() == 0)
            begin
                $error("status strobed with none outstanding");
                error_count++;
            end
            else
            begin
                oldest = awaited_status.pop_front();
                check_field("pixel_index", oldest.pixel_index, rsp.pixel_index);
                check_field("pixel_red", oldest.pixel_red, rsp.pixel_red);
                check_field("pixel_green", oldest.pixel_green, rsp.pixel_green);
                check_field("pixel_blue", oldest.pixel_blue, rsp.pixel_blue);
                check_field("updated_mask", oldest.updated_mask, rsp.updated_mask);
                check_field("has_tiles", oldest.has_tiles, rsp.has_tiles);
                check_field("border_index", oldest.border_index, rsp.border_index);
                check_field("border_known", oldest.border_known, rsp.border_known);
                check_field("transparent_index", oldest.transparent_index,
                            rsp.transparent_index);
                check_field("transparent_known", oldest.transparent_known,
                            rsp.transparent_known);
                check_field("is_tile_packet", oldest.is_tile_packet, rsp.is_tile_packet);
            end
        end
    end

    // Full-screen fills and the clearing pass after reset are the slowest items;
    // this bound sits well above the slowest correct run.
    initial
    begin
        #200ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        rewind_image();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_reads();
        test_packet_filter();
        test_presets();
        drain();
        test_tiles();
        test_palette_and_transparent();
        test_scrolls();
        test_random_items(73);

        drain();
        repeat (100) @(posedge clk);
        if (awaited_status.size() != 0)
        begin
            $error("%0d statuses never arrived", awaited_status.size());
            error_count++;
        end

        $display("Sent %0d items (%0d tile packets, %0d full-screen fills or scrolls).",
                 items_sent, tiles_sent, fills_sent);
        $display("Checked %0d statuses field by field; %0d mismatches.",
                 statuses_seen, error_count);
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
